// ===== rtl/sitoa_pkg.sv =====
// ----------------------------------------------------------------------------
// sitoa_pkg
// Shared constants, control word types and the microprogram of the signed
// integer to decimal ASCII unit.
// ----------------------------------------------------------------------------
package sitoa_pkg;

   // Width of the converted integer, read as two's complement (8..32 here,
   // bounded by the 32-bit input transfer).
   localparam int VALUE_WIDTH   = 32;
   localparam int IN_DATA_W     = 32;
   localparam int OUT_DATA_W    = 16;
   localparam int CHAR_W        = 8;
   localparam int COUNT_W       = 4;

   // Decimal digits needed for the largest magnitude, 2^VALUE_WIDTH - 1 bound.
   localparam int NUM_DIGITS    = (VALUE_WIDTH * 30103) / 100000 + 1;
   localparam int BCD_W         = 4 * NUM_DIGITS;
   localparam int DIGIT_IDX_W   = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
   localparam int CNT_SUM_W     = (DIGIT_IDX_W + 1 > COUNT_W) ? DIGIT_IDX_W + 1 : COUNT_W;

   // Shift-and-add-3 conversion retires this many magnitude bits per step.
   localparam int BITS_PER_STEP = 4;
   localparam int NUM_SHIFTS    = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
   localparam int MAG_W         = NUM_SHIFTS * BITS_PER_STEP;
   localparam int SHIFT_CNT_W   = $clog2(NUM_SHIFTS + 1);

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

   // Microprogram addressing.
   localparam int PC_W = 3;
   localparam logic [PC_W-1:0] STEP_WAIT    = 3'd0;
   localparam logic [PC_W-1:0] STEP_CONVERT = 3'd1;
   localparam logic [PC_W-1:0] STEP_COUNT   = 3'd2;
   localparam logic [PC_W-1:0] STEP_SIGN    = 3'd3;
   localparam logic [PC_W-1:0] STEP_DIGIT   = 3'd4;
   localparam logic [PC_W-1:0] STEP_RETURN  = 3'd5;

   typedef enum logic [2:0] {
      COND_NEVER       = 3'd0,
      COND_ALWAYS      = 3'd1,
      COND_NO_INPUT    = 3'd2,
      COND_MORE_SHIFTS = 3'd3,
      COND_POSITIVE    = 3'd4,
      COND_MORE_DIGITS = 3'd5
   } cond_type;

   typedef struct packed {
      logic            load_en;
      logic            shift_en;
      logic            count_en;
      logic            sign_en;
      logic            digit_en;
      cond_type        cond;
      logic [PC_W-1:0] target;
   } ctrl_word_type;

   // Datapath status seen by the sequencer.
   typedef struct packed {
      logic in_valid;
      logic more_shifts;
      logic negative;
      logic more_digits;
      logic out_free;
   } status_type;

   // Actions issued to the datapath in the current cycle.
   typedef struct packed {
      logic ready;
      logic load;
      logic shift;
      logic count;
      logic sign;
      logic digit;
   } action_type;

   function automatic ctrl_word_type program_word(input logic [PC_W-1:0] pc);
      ctrl_word_type w;
      w = '{load_en: 1'b0, shift_en: 1'b0, count_en: 1'b0, sign_en: 1'b0,
            digit_en: 1'b0, cond: COND_ALWAYS, target: STEP_WAIT};
      unique case (pc)
         STEP_WAIT: begin
            w.load_en = 1'b1;
            w.cond    = COND_NO_INPUT;
            w.target  = STEP_WAIT;
         end
         STEP_CONVERT: begin
            w.shift_en = 1'b1;
            w.cond     = COND_MORE_SHIFTS;
            w.target   = STEP_CONVERT;
         end
         STEP_COUNT: begin
            w.count_en = 1'b1;
            w.cond     = COND_POSITIVE;
            w.target   = STEP_DIGIT;
         end
         STEP_SIGN: begin
            w.sign_en = 1'b1;
            w.cond    = COND_NEVER;
            w.target  = STEP_DIGIT;
         end
         STEP_DIGIT: begin
            w.digit_en = 1'b1;
            w.cond     = COND_MORE_DIGITS;
            w.target   = STEP_DIGIT;
         end
         default: begin
            w.cond   = COND_ALWAYS;
            w.target = STEP_WAIT;
         end
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/signed_int_to_decimal_ascii_unit.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit
// Converts a signed integer to its decimal ASCII text, one character per
// output transfer.
// ----------------------------------------------------------------------------
// One input transfer carries a signed two's complement integer. The unit
// sends its decimal text, most significant character first: a '-' for a
// negative value, then the digits without leading zeros ('0' for zero). Every
// character carries the run's total character count, and tlast marks the
// final one. A small microprogram runs the conversion: a wait step takes the
// input, shift-and-add-3 steps build the BCD digits four bits at a time, a
// count step finds the leading digit, then one step per character, which
// stalls while the output register is full, and a return step. The next
// input is taken only after the previous run is fully handed over to the
// output register.
module signed_int_to_decimal_ascii_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [sitoa_pkg::IN_DATA_W-1:0]  req_tdata,  // [31:0] value
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [sitoa_pkg::OUT_DATA_W-1:0] rsp_tdata,  // [7:0] character, [11:8] char_count
   output logic                             rsp_tlast   // last
);

   localparam int W = sitoa_pkg::VALUE_WIDTH;

   sitoa_pkg::status_type status;
   sitoa_pkg::action_type action;

   logic [W-1:0]                          raw;
   logic [W-1:0]                          mag;
   logic                                  neg_ff;
   logic [sitoa_pkg::MAG_W-1:0]           mag_ff;
   logic [sitoa_pkg::MAG_W-1:0]           mag_in;
   logic [sitoa_pkg::BCD_W-1:0]           bcd_ff;
   logic [sitoa_pkg::BCD_W-1:0]           bcd_in;
   logic [sitoa_pkg::SHIFT_CNT_W-1:0]     shift_cnt_ff;
   logic [sitoa_pkg::DIGIT_IDX_W-1:0]     dig_idx_ff;
   logic [sitoa_pkg::DIGIT_IDX_W-1:0]     top_digit;
   logic [sitoa_pkg::CNT_SUM_W-1:0]       count_sum;
   logic [sitoa_pkg::COUNT_W-1:0]         count_ff;
   logic [3:0]                            cur_digit;
   logic                                  rsp_valid_ff;
   logic [sitoa_pkg::CHAR_W-1:0]          rsp_char_ff;
   logic [sitoa_pkg::COUNT_W-1:0]         rsp_count_ff;
   logic                                  rsp_last_ff;

   function automatic logic [sitoa_pkg::BCD_W+sitoa_pkg::MAG_W-1:0] dabble_step(
      input logic [sitoa_pkg::BCD_W+sitoa_pkg::MAG_W-1:0] v_in
   );
      logic [sitoa_pkg::BCD_W+sitoa_pkg::MAG_W-1:0] v;
      logic [3:0]                                   d;
      v = v_in;
      for (int s = 0; s < sitoa_pkg::BITS_PER_STEP; s++) begin
         for (int k = 0; k < sitoa_pkg::NUM_DIGITS; k++) begin
            d = v[sitoa_pkg::MAG_W + 4*k +: 4];
            if (d >= 4'd5) begin
               v[sitoa_pkg::MAG_W + 4*k +: 4] = d + 4'd3;
            end
         end
         v = v << 1;
      end
      return v;
   endfunction

   sitoa_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .action (action)
   );

   assign raw = req_tdata[W-1:0];
   assign mag = raw[W-1] ? (~raw + 1'b1) : raw;

   always_comb begin
      {bcd_in, mag_in} = dabble_step({bcd_ff, mag_ff});
   end

   // Index of the most significant nonzero digit; zero keeps one digit.
   always_comb begin
      top_digit = '0;
      for (int k = 0; k < sitoa_pkg::NUM_DIGITS; k++) begin
         if (bcd_ff[4*k +: 4] != 4'd0) begin
            top_digit = sitoa_pkg::DIGIT_IDX_W'(k);
         end
      end
   end

   assign count_sum = sitoa_pkg::CNT_SUM_W'(top_digit) + sitoa_pkg::CNT_SUM_W'(1)
                      + sitoa_pkg::CNT_SUM_W'(neg_ff);
   assign cur_digit = bcd_ff[4*dig_idx_ff +: 4];

   always_comb begin
      status.in_valid    = req_tvalid;
      status.more_shifts = shift_cnt_ff != sitoa_pkg::SHIFT_CNT_W'(1);
      status.negative    = neg_ff;
      status.more_digits = dig_idx_ff != '0;
      status.out_free    = !rsp_valid_ff || rsp_tready;
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (action.load) begin
         neg_ff       <= raw[W-1];
         mag_ff       <= sitoa_pkg::MAG_W'(mag);
         bcd_ff       <= '0;
         shift_cnt_ff <= sitoa_pkg::SHIFT_CNT_W'(sitoa_pkg::NUM_SHIFTS);
      end else if (action.shift) begin
         mag_ff       <= mag_in;
         bcd_ff       <= bcd_in;
         shift_cnt_ff <= shift_cnt_ff - 1'b1;
      end
      if (action.count) begin
         dig_idx_ff <= top_digit;
         count_ff   <= count_sum[sitoa_pkg::COUNT_W-1:0];
      end else if (action.digit) begin
         dig_idx_ff <= dig_idx_ff - 1'b1;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (action.sign || action.digit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (action.sign) begin
         rsp_char_ff  <= sitoa_pkg::CHAR_MINUS;
         rsp_count_ff <= count_ff;
         rsp_last_ff  <= 1'b0;
      end else if (action.digit) begin
         rsp_char_ff  <= sitoa_pkg::CHAR_ZERO + {4'd0, cur_digit};
         rsp_count_ff <= count_ff;
         rsp_last_ff  <= dig_idx_ff == '0;
      end
   end

   assign req_tready = action.ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(sitoa_pkg::OUT_DATA_W - sitoa_pkg::CHAR_W - sitoa_pkg::COUNT_W){1'b0}},
                        rsp_count_ff, rsp_char_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== rtl/sitoa_seq.sv =====
// ----------------------------------------------------------------------------
// sitoa_seq
// Microcode sequencer: step counter, program table and branch logic.
// ----------------------------------------------------------------------------
module sitoa_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  sitoa_pkg::status_type status,
   output sitoa_pkg::action_type action
);

   logic [sitoa_pkg::PC_W-1:0] pc_ff;
   logic [sitoa_pkg::PC_W-1:0] pc_in;
   sitoa_pkg::ctrl_word_type   word;
   logic                       stall;
   logic                       taken;

   assign word = sitoa_pkg::program_word(pc_ff);

   // A step that emits a character waits until the output register is free.
   assign stall = (word.sign_en || word.digit_en) && !status.out_free;

   always_comb begin
      unique case (word.cond)
         sitoa_pkg::COND_NEVER:       taken = 1'b0;
         sitoa_pkg::COND_ALWAYS:      taken = 1'b1;
         sitoa_pkg::COND_NO_INPUT:    taken = !status.in_valid;
         sitoa_pkg::COND_MORE_SHIFTS: taken = status.more_shifts;
         sitoa_pkg::COND_POSITIVE:    taken = !status.negative;
         sitoa_pkg::COND_MORE_DIGITS: taken = status.more_digits;
         default:                     taken = 1'b1;
      endcase
   end

   always_comb begin
      if (stall) begin
         pc_in = pc_ff;
      end else if (taken) begin
         pc_in = word.target;
      end else begin
         pc_in = pc_ff + 1'b1;
      end
   end

   // No input transfer is taken while reset is held.
   always_comb begin
      action.ready = word.load_en && !reset;
      action.load  = word.load_en && status.in_valid && !reset;
      action.shift = word.shift_en;
      action.count = word.count_en;
      action.sign  = word.sign_en && !stall;
      action.digit = word.digit_en && !stall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= sitoa_pkg::STEP_WAIT;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

// ===== rtl/sitoa_checker.sv =====
// ----------------------------------------------------------------------------
// sitoa_port_checks
// Port-level checks on the character stream of the conversion unit.
// ----------------------------------------------------------------------------
module sitoa_port_checks (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [31:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast
);

   // A character held back by the consumer stays unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled character changed");

   // Only a minus sign or a decimal digit is ever sent.
   a_char_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:0] == 8'd45
                  || (rsp_tdata[7:0] >= 8'd48 && rsp_tdata[7:0] <= 8'd57))
      else $error("character is not a sign or digit");

   // The sign always leads a run that still has digits to come.
   a_sign_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[7:0] == 8'd45 |-> !rsp_tlast)
      else $error("sign marked as last character");

   // A 32-bit value yields between one and eleven characters.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[11:8] >= 4'd1 && rsp_tdata[11:8] <= 4'd11
                  && rsp_tdata[15:12] == 4'd0)
      else $error("character count out of range");

   // No new value is taken while a character other than a run's last waits on the output.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |-> !rsp_tvalid || rsp_tready || rsp_tlast)
      else $error("input taken during an unfinished run");

endmodule

bind signed_int_to_decimal_ascii_unit sitoa_port_checks u_port_checks (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
